FILE: rtl/core/adsc_pkg.sv
// Types and constants for the ambient dark screen controller.
// Register indexes, field widths and register reset values.
// No dependencies.
package adsc_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned THR_W      = 16;
  localparam int unsigned RUN_W      = 8;
  localparam int unsigned LEVEL_W    = 8;

  typedef logic [RUN_W-1:0]   run_t;
  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [THR_W-1:0]   thr_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AUTO_OFF_ENABLE       = 3'd0,
    CFG_DARK_THRESHOLD        = 3'd1,
    CFG_BRIGHT_THRESHOLD      = 3'd2,
    CFG_DARK_SAMPLES_NEEDED   = 3'd3,
    CFG_BRIGHT_SAMPLES_NEEDED = 3'd4,
    CFG_FALLBACK_BRIGHTNESS   = 3'd5
  } cfg_idx_t;

  localparam thr_t   RST_DARK_THRESHOLD    = 16'd8;
  localparam thr_t   RST_BRIGHT_THRESHOLD  = 16'd20;
  localparam run_t   RST_DARK_NEEDED       = 8'd4;
  localparam run_t   RST_BRIGHT_NEEDED     = 8'd2;
  localparam level_t RST_FALLBACK          = 8'd60;
  localparam run_t   RUN_MAX               = 8'hFF;

  function automatic run_t run_inc(input run_t r);
    return (r == RUN_MAX) ? r : r + run_t'(1);
  endfunction

endpackage

FILE: rtl/core/ambient_dark_screen_controller.sv
// Ambient dark screen controller: light hysteresis with persistence counts,
// screen blanking and touch override. Single registered pass per request.
// Depends on adsc_pkg.
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------
//  in      | in_valid/in_stall  | action, light_count, read_ok, current_brightness
//  out     | out_valid/out_stall| backlight_write/value, screen_is_off, level,
//          |                    | sensor_power, touch_accepted
//  cfg     | cfg_wr_en          | cfg_index, cfg_data
//
// One request per cycle while in_stall is low; each result appears in the cycle
// after its request, in the single result register, refilled on each accepted request.
// in_stall is high only while a result is held and out_stall is high.
// rst_n is synchronous, active low; it restores register and state defaults.
module ambient_dark_screen_controller #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [adsc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [adsc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_action,
  input  logic [COUNT_BITS-1:0]             in_light_count,
  input  logic                              in_read_ok,
  input  logic [adsc_pkg::LEVEL_W-1:0]      in_current_brightness,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_backlight_write,
  output logic [adsc_pkg::LEVEL_W-1:0]      out_backlight_value,
  output logic                              out_screen_is_off,
  output logic                              out_level_valid,
  output logic [COUNT_BITS-1:0]             out_ambient_level,
  output logic                              out_sensor_power,
  output logic                              out_touch_accepted
);

  localparam int unsigned CMP_W = (COUNT_BITS > adsc_pkg::THR_W) ? COUNT_BITS : adsc_pkg::THR_W;

  logic                    auto_off_enable_r;
  adsc_pkg::thr_t          dark_threshold_r;
  adsc_pkg::thr_t          bright_threshold_r;
  adsc_pkg::run_t          dark_needed_r;
  adsc_pkg::run_t          bright_needed_r;
  adsc_pkg::level_t        fallback_r;

  logic                    sensor_active_r, sensor_active_nxt;
  logic                    screen_blanked_r, screen_blanked_nxt;
  logic                    manual_override_r, manual_override_nxt;
  adsc_pkg::run_t          dark_run_r, dark_run_nxt;
  adsc_pkg::run_t          bright_run_r, bright_run_nxt;
  adsc_pkg::level_t        saved_level_r, saved_level_nxt;
  logic [COUNT_BITS-1:0]   last_count_r, last_count_nxt;
  logic                    count_known_r, count_known_nxt;

  logic                    wr_nxt;
  adsc_pkg::level_t        wr_value_nxt;
  logic                    touch_nxt;

  logic                    out_valid_r;
  logic                    backlight_write_r;
  adsc_pkg::level_t        backlight_value_r;
  logic                    screen_is_off_r;
  logic                    level_valid_r;
  logic [COUNT_BITS-1:0]   ambient_level_r;
  logic                    sensor_power_r;
  logic                    touch_accepted_r;

  logic                    in_accept;

  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;

  always_comb begin
    logic is_bright;
    logic is_dark;
    is_bright           = CMP_W'(in_light_count) >= CMP_W'(bright_threshold_r);
    is_dark             = CMP_W'(in_light_count) <= CMP_W'(dark_threshold_r);
    sensor_active_nxt   = sensor_active_r;
    screen_blanked_nxt  = screen_blanked_r;
    manual_override_nxt = manual_override_r;
    dark_run_nxt        = dark_run_r;
    bright_run_nxt      = bright_run_r;
    saved_level_nxt     = saved_level_r;
    last_count_nxt      = last_count_r;
    count_known_nxt     = count_known_r;
    wr_nxt              = 1'b0;
    wr_value_nxt        = '0;
    touch_nxt           = 1'b0;

    if (in_action) begin
      if (screen_blanked_r) begin
        manual_override_nxt = 1'b1;
        screen_blanked_nxt  = 1'b0;
        wr_nxt              = 1'b1;
        wr_value_nxt        = saved_level_r;
        touch_nxt           = 1'b1;
      end
    end else begin
      if (auto_off_enable_r != sensor_active_r) begin
        if (!auto_off_enable_r) begin
          if (screen_blanked_r) begin
            screen_blanked_nxt = 1'b0;
            wr_nxt             = 1'b1;
            wr_value_nxt       = saved_level_r;
          end
          count_known_nxt = 1'b0;
        end
        sensor_active_nxt   = auto_off_enable_r;
        manual_override_nxt = 1'b0;
        dark_run_nxt        = '0;
        bright_run_nxt      = '0;
      end
      if (sensor_active_nxt && in_read_ok) begin
        last_count_nxt  = in_light_count;
        count_known_nxt = 1'b1;
        if (is_bright) begin
          bright_run_nxt = adsc_pkg::run_inc(bright_run_nxt);
          dark_run_nxt   = '0;
        end else if (is_dark) begin
          dark_run_nxt   = adsc_pkg::run_inc(dark_run_nxt);
          bright_run_nxt = '0;
        end else begin
          dark_run_nxt   = '0;
          bright_run_nxt = '0;
        end
        if (is_bright || is_dark) begin
          if (bright_run_nxt >= bright_needed_r) begin
            bright_run_nxt      = '0;
            manual_override_nxt = 1'b0;
            if (screen_blanked_nxt) begin
              screen_blanked_nxt = 1'b0;
              wr_nxt             = 1'b1;
              wr_value_nxt       = saved_level_nxt;
            end
          end else if (dark_run_nxt >= dark_needed_r) begin
            dark_run_nxt = '0;
            if (!screen_blanked_nxt && !manual_override_nxt) begin
              saved_level_nxt    = (in_current_brightness == '0) ? fallback_r
                                                                 : in_current_brightness;
              wr_nxt             = 1'b1;
              wr_value_nxt       = '0;
              screen_blanked_nxt = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auto_off_enable_r  <= 1'b1;
      dark_threshold_r   <= adsc_pkg::RST_DARK_THRESHOLD;
      bright_threshold_r <= adsc_pkg::RST_BRIGHT_THRESHOLD;
      dark_needed_r      <= adsc_pkg::RST_DARK_NEEDED;
      bright_needed_r    <= adsc_pkg::RST_BRIGHT_NEEDED;
      fallback_r         <= adsc_pkg::RST_FALLBACK;
    end else if (cfg_wr_en) begin
      case (adsc_pkg::cfg_idx_t'(cfg_index))
        adsc_pkg::CFG_AUTO_OFF_ENABLE:       auto_off_enable_r  <= cfg_data[0];
        adsc_pkg::CFG_DARK_THRESHOLD:        dark_threshold_r   <= cfg_data;
        adsc_pkg::CFG_BRIGHT_THRESHOLD:      bright_threshold_r <= cfg_data;
        adsc_pkg::CFG_DARK_SAMPLES_NEEDED:   dark_needed_r      <= cfg_data[adsc_pkg::RUN_W-1:0];
        adsc_pkg::CFG_BRIGHT_SAMPLES_NEEDED: bright_needed_r    <= cfg_data[adsc_pkg::RUN_W-1:0];
        adsc_pkg::CFG_FALLBACK_BRIGHTNESS:   fallback_r         <= cfg_data[adsc_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sensor_active_r   <= 1'b0;
      screen_blanked_r  <= 1'b0;
      manual_override_r <= 1'b0;
      dark_run_r        <= '0;
      bright_run_r      <= '0;
      saved_level_r     <= adsc_pkg::RST_FALLBACK;
      last_count_r      <= '0;
      count_known_r     <= 1'b0;
    end else if (in_accept) begin
      sensor_active_r   <= sensor_active_nxt;
      screen_blanked_r  <= screen_blanked_nxt;
      manual_override_r <= manual_override_nxt;
      dark_run_r        <= dark_run_nxt;
      bright_run_r      <= bright_run_nxt;
      saved_level_r     <= saved_level_nxt;
      last_count_r      <= last_count_nxt;
      count_known_r     <= count_known_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      backlight_write_r <= wr_nxt;
      backlight_value_r <= wr_value_nxt;
      screen_is_off_r   <= screen_blanked_nxt;
      level_valid_r     <= count_known_nxt;
      ambient_level_r   <= count_known_nxt ? last_count_nxt : '0;
      sensor_power_r    <= sensor_active_nxt;
      touch_accepted_r  <= touch_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_backlight_write = backlight_write_r;
  assign out_backlight_value = backlight_value_r;
  assign out_screen_is_off   = screen_is_off_r;
  assign out_level_valid     = level_valid_r;
  assign out_ambient_level   = ambient_level_r;
  assign out_sensor_power    = sensor_power_r;
  assign out_touch_accepted  = touch_accepted_r;

`ifndef SYNTH
  a_no_value_without_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !backlight_write_r |-> backlight_value_r == '0)
    else $error("backlight value set without a write");

  a_touch_wakes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && touch_accepted_r |-> backlight_write_r && !screen_is_off_r)
    else $error("accepted touch did not wake the screen");

  a_level_needs_sensor: assert property (@(posedge clk) disable iff (!rst_n)
    !sensor_active_r |-> !count_known_r)
    else $error("level held while sensor is off");

  a_blank_excludes_override: assert property (@(posedge clk) disable iff (!rst_n)
    screen_blanked_r |-> !manual_override_r)
    else $error("screen blanked while override is set");

  a_state_holds_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_accept |=> $stable(screen_blanked_r) && $stable(saved_level_r))
    else $error("state changed without an accepted request");
`endif

endmodule
